### rtl/core/idte_pkg.sv
// ----------------------------------------------------------------------------
// idte_pkg: shared types, constants and calendar helpers
// Widths, fault codes, pipeline payload structs and the small month tables
// used by the calendar pipeline.
// ----------------------------------------------------------------------------
package idte_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MON_W   = 7;
    localparam int unsigned DAY_W   = 7;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned FAULT_W = 3;
    localparam int unsigned EDAY_W  = 22;
    localparam int unsigned ESEC_W  = 38;
    localparam int unsigned Q_W     = 8;
    localparam int unsigned MIDX_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // fault codes, first one found wins
    localparam logic [FAULT_W-1:0] FAULT_NONE   = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_FORMAT = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_YEAR   = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_MONTH  = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_DAY    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_CEIL  = 1'b1;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR      = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST  = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_CEIL_RST   = 14'd9999;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;

    // character positions inside YYYY-MM-DD
    localparam logic [POS_W-1:0] POS_DASH1 = 4'd4;
    localparam logic [POS_W-1:0] POS_DASH2 = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST  = 4'd9;
    localparam logic [POS_W-1:0] POS_LEN   = 4'd10;
    localparam logic [POS_W-1:0] POS_MAX   = 4'd15;

    localparam logic [MON_W-1:0] MONTH_MAX = 7'd12;
    localparam logic [MIDX_W-1:0] MIDX_FEB = 4'd1;

    localparam logic [8:0]        DAYS_PER_YEAR   = 9'd365;
    localparam logic [16:0]       SECONDS_PER_DAY = 17'd86400;
    localparam logic [EDAY_W-1:0] LEAPS_BEFORE_EPOCH = 22'd477;  // leap years in 1..1969
    localparam logic [EDAY_W-1:0] MAX_EPOCH_DAYS     = 22'd2932896;

    // x / 25 for x < 4096 as a reciprocal multiply
    localparam logic [12:0] DIV25_MUL = 13'd5243;
    localparam int unsigned DIV25_SH  = 17;

    typedef struct packed {
        logic              fmt_bad;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } t_date_s1;

    typedef struct packed {
        logic [FAULT_W-1:0] fault;
        logic [YEAR_W-1:0]  year;
        logic [MIDX_W-1:0]  mon_idx;
        logic [DAY_W-1:0]   day;
        logic [Q_W-1:0]     n_q100;
        logic [Q_W-1:0]     n_q400;
        logic [Q_W-1:0]     y_q100;
        logic [Q_W-1:0]     y_q400;
    } t_cal_s2;

    typedef struct packed {
        logic [FAULT_W-1:0] fault;
        logic [EDAY_W-1:0]  year_days;
        logic [EDAY_W-1:0]  extra_days;
    } t_cal_s3;

    typedef struct packed {
        logic [FAULT_W-1:0] fault;
        logic [EDAY_W-1:0]  days;
    } t_cal_s4;

    // load enables of the calendar stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    function automatic logic [Q_W-1:0] div25(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'(DIV25_MUL);
        return p[DIV25_SH +: Q_W];
    endfunction

    function automatic logic [8:0] days_before_month(input logic [MIDX_W-1:0] mi);
        logic [8:0] r;
        case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [MIDX_W-1:0] mi);
        logic [4:0] r;
        case (mi)
            4'd1:                       r = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    r = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6,
            4'd7, 4'd9, 4'd11:          r = 5'd31;
            default:                    r = 5'd0;
        endcase
        return r;
    endfunction

    // gregorian rule from y and the quotients (y/4)/25 and (y/16)/25
    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [Q_W-1:0] q100,
                                     input logic [Q_W-1:0] q400);
        logic by4, by100, by400;
        by4   = (y[1:0] == 2'd0);
        by100 = by4 && (y[YEAR_W-1:2] == 12'(12'(q100) * 12'd25));
        by400 = (y[3:0] == 4'd0) && (y[YEAR_W-1:4] == 10'(12'(q400) * 12'd25));
        return (by4 && !by100) || by400;
    endfunction

endpackage

### rtl/core/iso_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// iso_date_to_epoch_seconds: ISO 8601 calendar date to Unix time
// Parses a YYYY-MM-DD character stream and returns the epoch day count and
// the Unix time of midnight of that date, or a fault code.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input transaction (tlast on the
// last one) and accepts a character in every cycle. Only the last character
// of a string produces a result transaction, through the parser's field
// register, three calendar stages (checks, leap rule and year product, day
// sum) and the seconds multiply into the output register. The stages
// advance independently, so up to five results can queue while the output
// side stalls; the input side stalls only when all five are full. A result
// carries a valid flag and a fault code (format, year out of the configured
// range or below 1970, month, day); the day count and seconds read zero on
// any fault. The user must write the year floor and ceiling through the
// configuration port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module iso_date_to_epoch_seconds
    import idte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [YEAR_W-1:0]    i_cfg_wdata,
    // character stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,    // [7:0] char_code
    input  logic                 s_axis_tlast,    // is_final
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,    // [21:0] epoch_days, [59:22] epoch_seconds
    output logic [3:0]           m_axis_tuser     // [0] date_ok, [3:1] fault_code
);

    localparam int unsigned STAGES = 5;

    logic [YEAR_W-1:0]  r_year_floor;
    logic [YEAR_W-1:0]  r_year_ceil;
    logic [STAGES-1:0]  r_vld;        // s1..s5, s5 is the output register
    logic [STAGES-1:0]  stage_en;
    logic               in_accept;
    t_pipe_en           pipe_en;
    t_date_s1           s1;
    t_cal_s4            s4;

    logic [FAULT_W-1:0] r_out_fault;
    logic [EDAY_W-1:0]  r_out_days;
    logic [ESEC_W-1:0]  r_out_secs;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_floor <= YEAR_FLOOR_RST;
            r_year_ceil  <= YEAR_CEIL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_YEAR_FLOOR: r_year_floor <= i_cfg_wdata;
                CFG_YEAR_CEIL:  r_year_ceil  <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[0];
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pipe_en.s2    = stage_en[1];
    assign pipe_en.s3    = stage_en[2];
    assign pipe_en.s4    = stage_en[3];

    // only the last character of a string starts a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= in_accept && s_axis_tlast;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    idte_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_s1     (s1)
    );

    idte_calendar u_calendar (
        .i_clk        (i_clk),
        .i_en         (pipe_en),
        .i_s1         (s1),
        .i_year_floor (r_year_floor),
        .i_year_ceil  (r_year_ceil),
        .o_s4         (s4)
    );

    // output register: days to seconds, zero days give zero seconds
    always_ff @(posedge i_clk) begin
        if (stage_en[STAGES-1]) begin
            r_out_fault <= s4.fault;
            r_out_days  <= s4.days;
            r_out_secs  <= ESEC_W'(ESEC_W'(s4.days) * ESEC_W'(SECONDS_PER_DAY));
        end
    end

    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {4'b0000, r_out_secs, r_out_days};
    assign m_axis_tuser  = {r_out_fault, (r_out_fault == FAULT_NONE)};

    // a faulted result carries no time
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tdata[21:0] == '0 && m_axis_tdata[59:22] == '0))
        else $error("faulted result with nonzero time");

    // day count never passes the last day of year 9999
    a_days_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:0] <= MAX_EPOCH_DAYS))
        else $error("epoch day count out of range");

    // a full pipeline with a stalled output must stall the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is full");

    // the last character of a string always starts a result
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> r_vld[0])
        else $error("final character lost");

endmodule

### rtl/core/idte_parser.sv
// ----------------------------------------------------------------------------
// idte_parser: character stream parser
// Checks the YYYY-MM-DD format one character per transaction, gathers the
// year, month and day digits and hands the finished fields to the pipeline.
// ----------------------------------------------------------------------------
module idte_parser
    import idte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_date_s1          o_s1
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [MON_W-1:0]  r_month, n_month;
    logic [DAY_W-1:0]  r_day, n_day;
    logic              r_fmt_bad, n_fmt_bad;
    t_date_s1          r_s1;

    logic       is_digit;
    logic [3:0] digit;

    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign digit    = is_digit ? i_char[3:0] : 4'd0;

    always_comb begin
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_fmt_bad = r_fmt_bad;
        if (r_pos >= POS_LEN) begin
            n_fmt_bad = 1'b1;
        end else if (r_pos == POS_DASH1 || r_pos == POS_DASH2) begin
            if (i_char != CHAR_DASH) begin
                n_fmt_bad = 1'b1;
            end
        end else if (!is_digit) begin
            n_fmt_bad = 1'b1;
        end else if (r_pos < POS_DASH1) begin
            n_year = YEAR_W'(r_year * YEAR_W'(10) + YEAR_W'(digit));
        end else if (r_pos < POS_DASH2) begin
            n_month = MON_W'(r_month * MON_W'(10) + MON_W'(digit));
        end else begin
            n_day = DAY_W'(r_day * DAY_W'(10) + DAY_W'(digit));
        end
        n_pos = (r_pos != POS_MAX) ? POS_W'(r_pos + 4'd1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_fmt_bad <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos     <= '0;
                r_year    <= '0;
                r_month   <= '0;
                r_day     <= '0;
                r_fmt_bad <= 1'b0;
            end else begin
                r_pos     <= n_pos;
                r_year    <= n_year;
                r_month   <= n_month;
                r_day     <= n_day;
                r_fmt_bad <= n_fmt_bad;
            end
        end
    end

    // wrong length counts as a format fault
    always_ff @(posedge i_clk) begin
        if (i_accept && i_last) begin
            r_s1.fmt_bad <= n_fmt_bad || (r_pos != POS_LAST);
            r_s1.year    <= n_year;
            r_s1.month   <= n_month;
            r_s1.day     <= n_day;
        end
    end

    assign o_s1 = r_s1;

endmodule

### rtl/core/idte_calendar.sv
// ----------------------------------------------------------------------------
// idte_calendar: date checks and day count
// Three stages: range checks and year quotients, leap and day checks with
// the year product, then the final day sum.
// ----------------------------------------------------------------------------
module idte_calendar
    import idte_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  t_date_s1          i_s1,
    input  logic [YEAR_W-1:0] i_year_floor,
    input  logic [YEAR_W-1:0] i_year_ceil,
    output t_cal_s4           o_s4
);

    t_cal_s2 r_s2, n_s2;
    t_cal_s3 r_s3, n_s3;
    t_cal_s4 r_s4, n_s4;

    logic [YEAR_W-1:0] s1_prev_year;
    logic [YEAR_W-1:0] s2_prev_year;
    logic              s2_leap;
    logic [4:0]        s2_mlen;
    logic [EDAY_W-1:0] s2_leaps;

    // stage 2: format, year and month checks, quotients for the leap rule
    always_comb begin
        s1_prev_year = YEAR_W'(i_s1.year - 14'd1);
        if (i_s1.fmt_bad) begin
            n_s2.fault = FAULT_FORMAT;
        end else if (i_s1.year < EPOCH_YEAR || i_s1.year < i_year_floor ||
                     i_s1.year > i_year_ceil) begin
            n_s2.fault = FAULT_YEAR;
        end else if (i_s1.month == '0 || i_s1.month > MONTH_MAX) begin
            n_s2.fault = FAULT_MONTH;
        end else begin
            n_s2.fault = FAULT_NONE;
        end
        n_s2.year    = i_s1.year;
        n_s2.mon_idx = MIDX_W'(i_s1.month - 7'd1);
        n_s2.day     = i_s1.day;
        n_s2.n_q100  = div25(s1_prev_year[YEAR_W-1:2]);
        n_s2.n_q400  = div25({2'b00, s1_prev_year[YEAR_W-1:4]});
        n_s2.y_q100  = div25(i_s1.year[YEAR_W-1:2]);
        n_s2.y_q400  = div25({2'b00, i_s1.year[YEAR_W-1:4]});
    end

    // stage 3: day check, whole years times 365, remaining small terms
    always_comb begin
        s2_prev_year = YEAR_W'(r_s2.year - 14'd1);
        s2_leap      = is_leap(r_s2.year, r_s2.y_q100, r_s2.y_q400);
        s2_mlen      = month_len(r_s2.mon_idx) +
                       5'((r_s2.mon_idx == MIDX_FEB) && s2_leap);
        if (r_s2.fault == FAULT_NONE &&
            (r_s2.day == '0 || r_s2.day > DAY_W'(s2_mlen))) begin
            n_s3.fault = FAULT_DAY;
        end else begin
            n_s3.fault = r_s2.fault;
        end
        n_s3.year_days = EDAY_W'(EDAY_W'(YEAR_W'(r_s2.year - EPOCH_YEAR)) *
                                 EDAY_W'(DAYS_PER_YEAR));
        s2_leaps = EDAY_W'(s2_prev_year[YEAR_W-1:2]) - EDAY_W'(r_s2.n_q100) +
                   EDAY_W'(r_s2.n_q400) - LEAPS_BEFORE_EPOCH;
        n_s3.extra_days = s2_leaps + EDAY_W'(days_before_month(r_s2.mon_idx)) +
                          EDAY_W'((r_s2.mon_idx > MIDX_FEB) && s2_leap) +
                          EDAY_W'(r_s2.day) - 22'd1;
    end

    // stage 4: day sum, zero on any fault
    always_comb begin
        n_s4.fault = r_s3.fault;
        n_s4.days  = (r_s3.fault == FAULT_NONE) ?
                     EDAY_W'(r_s3.year_days + r_s3.extra_days) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2 <= n_s2;
        end
        if (i_en.s3) begin
            r_s3 <= n_s3;
        end
        if (i_en.s4) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule
